>>> src/length_framed_xor_deframer_defines.svh
// assertion macros used by the checker file
`ifndef LENGTH_FRAMED_XOR_DEFRAMER_DEFINES_SVH
`define LENGTH_FRAMED_XOR_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked only out of reset
`define LFXD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked only out of reset
`define LFXD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/lfxd_pkg.sv
package lfxd_pkg;

  localparam int MaxFrame = 64;

  localparam logic [7:0] MIN_LENGTH_BYTE = 8'd3;
  localparam logic [8:0] HEADER_EXTRA    = 9'd2;

  localparam logic [1:0] ST_BUSY   = 2'd0;
  localparam logic [1:0] ST_GOOD   = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;
  localparam logic [1:0] ST_LENGTH = 2'd3;

  // byte held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } lfxd_item_t;

  // one tagged output byte
  typedef struct packed {
    logic [7:0] frame_byte;
    logic [5:0] byte_position;
    logic       frame_end;
    logic [1:0] frame_status;
  } lfxd_result_t;

endpackage

>>> src/length_framed_xor_deframer.sv
// length-framed bus byte deframer with xor checksum check
// input channel: in_valid / in_stall carry one received byte (in_rx_byte) per transaction
// output channel: out_valid / out_stall carry one tagged byte per input byte:
//   out_frame_byte (the byte), out_byte_position (0 = sender), out_frame_end and
//   out_frame_status (0 busy, 1 checksum good, 2 checksum bad, 3 length invalid)
// frame layout: sender, length, receiver, message id, data, checksum; total = length + 2
// data path: the byte is registered in the input register, then passes through the frame
//   logic into the output register
// throughput: one byte per cycle while the receiver does not stall; the frame state is a
//   single xor and counter update between the input register and the output register
// reset (rst_n low, synchronous): both registers empty, position, total and xor cleared,
//   the next byte is taken as a sender
// when the receiver stalls, the output register holds; one more byte waits in the input
//   register, after which in_stall rises in the same cycle as out_stall
module length_framed_xor_deframer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_frame_byte,
  output logic [5:0] out_byte_position,
  output logic       out_frame_end,
  output logic [1:0] out_frame_status
);
  import lfxd_pkg::*;

  lfxd_item_t   item;
  lfxd_result_t result;
  lfxd_result_t held;
  logic         out_free;
  logic         advance;

  // held byte moves into the output register when that register can take it
  assign advance = item.valid && out_free;

  lfxd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .in_stall   (in_stall),
    .item       (item)
  );

  // position, expected total and running xor update once per moved byte
  lfxd_frame_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item),
    .advance (advance),
    .result  (result)
  );

  lfxd_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .result    (result),
    .out_stall (out_stall),
    .out_free  (out_free),
    .out_valid (out_valid),
    .held      (held)
  );

  assign out_frame_byte    = held.frame_byte;
  assign out_byte_position = held.byte_position;
  assign out_frame_end     = held.frame_end;
  assign out_frame_status  = held.frame_status;

endmodule

>>> src/lfxd_in_reg.sv
module lfxd_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_rx_byte,
  input  logic               advance,
  output logic               in_stall,
  output lfxd_pkg::lfxd_item_t item
);
  import lfxd_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       take;

  // hold while the held byte cannot move on
  assign in_stall = valid_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_rx_byte;
    end
  end

  assign item.valid   = valid_r;
  assign item.rx_byte = byte_r;

endmodule

>>> src/lfxd_frame_core.sv
module lfxd_frame_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  lfxd_pkg::lfxd_item_t   item,
  input  logic                   advance,
  output lfxd_pkg::lfxd_result_t result
);
  import lfxd_pkg::*;

  logic [5:0] pos_r, pos_nxt;
  logic [6:0] total_r, total_nxt;
  logic [7:0] xor_r, xor_nxt;

  logic [7:0] b;
  logic [8:0] total9;
  logic       length_bad;
  logic       is_last;
  logic       end_c;
  logic [1:0] status_c;

  assign b          = item.rx_byte;
  assign total9     = {1'b0, b} + HEADER_EXTRA;
  assign length_bad = (b < MIN_LENGTH_BYTE) || (total9 > 9'(MaxFrame));
  // also catches a position at or past the last one
  assign is_last    = ({1'b0, pos_r} + 7'd1) >= total_r;

  always_comb begin
    pos_nxt   = pos_r;
    total_nxt = total_r;
    xor_nxt   = xor_r;
    end_c     = 1'b0;
    status_c  = ST_BUSY;
    if (pos_r == 6'd0) begin
      xor_nxt = b;
      pos_nxt = 6'd1;
    end else if (pos_r == 6'd1) begin
      if (length_bad) begin
        end_c     = 1'b1;
        status_c  = ST_LENGTH;
        pos_nxt   = 6'd0;
        total_nxt = 7'd0;
        xor_nxt   = 8'd0;
      end else begin
        total_nxt = total9[6:0];
        xor_nxt   = xor_r ^ b;
        pos_nxt   = 6'd2;
      end
    end else if (is_last) begin
      end_c     = 1'b1;
      status_c  = (xor_r == b) ? ST_GOOD : ST_BAD;
      pos_nxt   = 6'd0;
      total_nxt = 7'd0;
      xor_nxt   = 8'd0;
    end else begin
      xor_nxt = xor_r ^ b;
      pos_nxt = pos_r + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      total_r <= '0;
      xor_r   <= '0;
    end else if (advance) begin
      pos_r   <= pos_nxt;
      total_r <= total_nxt;
      xor_r   <= xor_nxt;
    end
  end

  assign result.frame_byte    = b;
  assign result.byte_position = pos_r;
  assign result.frame_end     = end_c;
  assign result.frame_status  = status_c;

endmodule

>>> src/lfxd_out_reg.sv
module lfxd_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  lfxd_pkg::lfxd_result_t result,
  input  logic                   out_stall,
  output logic                   out_free,
  output logic                   out_valid,
  output lfxd_pkg::lfxd_result_t held
);
  import lfxd_pkg::*;

  logic         valid_r, valid_nxt;
  lfxd_result_t data_r;

  assign out_free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_free) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign held      = data_r;

endmodule

>>> src/lfxd_checker.sv
`include "length_framed_xor_deframer_defines.svh"

module lfxd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_frame_byte,
  input logic [5:0] out_byte_position,
  input logic       out_frame_end,
  input logic [1:0] out_frame_status
);
  import lfxd_pkg::*;

  // status is nonzero exactly when the frame ends
  `LFXD_ASSERT_NOW(a_end_status, out_valid, out_frame_end == (out_frame_status != ST_BUSY), "frame_end and frame_status disagree")

  // a length error can only come from the length byte
  `LFXD_ASSERT_NOW(a_length_pos, out_valid && (out_frame_status == ST_LENGTH), out_byte_position == 6'd1, "length error away from the length byte")

  // a checksum verdict needs at least a five byte frame
  `LFXD_ASSERT_NOW(a_check_pos, out_valid && (out_frame_status == ST_GOOD || out_frame_status == ST_BAD), out_byte_position >= 6'd4, "checksum verdict too early in the frame")

  // a stalled result holds
  `LFXD_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(out_frame_byte) && $stable(out_byte_position) && $stable(out_frame_end) && $stable(out_frame_status), "stalled result changed")

endmodule

bind length_framed_xor_deframer lfxd_checker u_lfxd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_frame_byte    (out_frame_byte),
  .out_byte_position (out_byte_position),
  .out_frame_end     (out_frame_end),
  .out_frame_status  (out_frame_status)
);
